// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the histogram block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define JWH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the standard clock and reset names of this project.
`define JWH_ASSERT_STD(lbl, prop, msg) \
  `JWH_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== src/jwh_pkg.sv =====
// Package with command types, codes and helpers of the jackknife histogram.
`timescale 1ns / 1ps
`default_nettype none
package jwh_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIN_IDX_W = 12;
  localparam int unsigned OP_W = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SKIP_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_LENGTH = 1'd1;

  localparam int unsigned CMD_FIFO_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = 2;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_READ,
    CMD_CLEAR
  } cmd_kind_e;

  // One command from the front end. For an add, value is the sample; for a read,
  // it is the zero-extended bin index. in_range says the value addresses a bin.
  typedef struct packed {
    cmd_kind_e          kind;
    logic               in_range;
    logic [WORD_W-1:0]  value;
  } cmd_t;

  function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
    sat_inc = (v == '1) ? v : v + WORD_W'(1);
  endfunction

endpackage
`default_nettype wire

// ===== src/jackknife_windowed_histogram_top.sv =====
// Top level of the jackknife windowed histogram.
//
// Input stream: s_axis_tuser carries the op (add, read, clear), s_axis_tdata the
// sample value and the bin index. Each add takes the next sample position since
// the last clear; positions inside [skip_start, skip_start + skip_length) are
// dropped. Only a read produces a beat on the output stream, which carries the
// bin frequency, running maximum, overflow count and kept total.
// The front end takes one beat per cycle, while the queue has room, into a
// four-entry command queue. The engine works on one command at a time over a
// single-port bin memory: an add to a bin reads the bin, then writes it back;
// an overflow add leaves the memory alone; a read passes the bin word on to the
// output register; a clear writes zero to every bin. Dropped and unused-op beats
// never reach the engine. After reset the engine sweeps all BINS entries to
// zero, one per cycle, and s_axis_tready stays low until the sweep ends;
// configuration writes are taken throughout. When the receiver stalls, the
// result waits in the output register and the queue keeps accepting until it
// fills.
`timescale 1ns / 1ps
`default_nettype none
module jackknife_windowed_histogram_top #(
  parameter int unsigned BINS = 4096
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // Fields from bit 0: sample_value[31:0], bin_index[43:32], zero pad [47:44].
  input  wire  [47:0]  s_axis_tdata,
  // Fields from bit 0: op[1:0].
  input  wire  [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // Fields from bit 0: bin_frequency, max_value, overflow_count, kept_total.
  output logic [127:0] m_axis_tdata,
  input  wire          cfg_we_i,
  input  wire  [0:0]   cfg_idx_i,
  input  wire  [31:0]  cfg_data_i
);

  jwh_pkg::cmd_t push_cmd, pop_cmd;
  logic          push, pop, fifo_full, fifo_empty, init_done;

  jwh_front #(.BINS(BINS)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_valid_i      (s_axis_tvalid),
    .s_ready_o      (s_axis_tready),
    .op_i           (s_axis_tuser),
    .sample_value_i (s_axis_tdata[31:0]),
    .bin_index_i    (s_axis_tdata[43:32]),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .init_done_i    (init_done),
    .fifo_full_i    (fifo_full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  jwh_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty)
  );

  jwh_back #(.BINS(BINS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (fifo_empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .init_done_o (init_done),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata)
  );

endmodule
`default_nettype wire

// ===== src/jwh_front.sv =====
// Front end: accepts beats, tracks sample position, drops excluded samples.
`timescale 1ns / 1ps
`default_nettype none
module jwh_front #(
  parameter int unsigned BINS = 4096
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_valid_i,
  output logic                                 s_ready_o,
  input  wire  [jwh_pkg::OP_W-1:0]             op_i,
  input  wire  [jwh_pkg::WORD_W-1:0]           sample_value_i,
  input  wire  [jwh_pkg::BIN_IDX_W-1:0]        bin_index_i,
  input  wire                                  cfg_we_i,
  input  wire  [jwh_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire  [jwh_pkg::WORD_W-1:0]           cfg_data_i,
  input  wire                                  init_done_i,
  input  wire                                  fifo_full_i,
  output logic                                 push_o,
  output jwh_pkg::cmd_t                        cmd_o
);

  localparam logic [jwh_pkg::WORD_W-1:0] BINS_W = jwh_pkg::WORD_W'(BINS);

  logic [jwh_pkg::WORD_W-1:0] skip_start_q, skip_length_q;
  logic [jwh_pkg::WORD_W-1:0] pos_q, pos_d;
  logic [jwh_pkg::WORD_W-1:0] pos_off;
  logic [jwh_pkg::WORD_W-1:0] bin_ext;
  logic                       accept;
  logic                       excluded;

  assign s_ready_o = init_done_i && !fifo_full_i;
  assign accept    = s_valid_i && s_ready_o;
  assign pos_off   = pos_q - skip_start_q;
  assign excluded  = (pos_q >= skip_start_q) && (pos_off < skip_length_q);
  assign bin_ext   = jwh_pkg::WORD_W'(bin_index_i);

  always_comb begin
    pos_d         = pos_q;
    push_o        = 1'b0;
    cmd_o.kind    = jwh_pkg::CMD_ADD;
    cmd_o.in_range = 1'b0;
    cmd_o.value   = sample_value_i;
    if (accept) begin
      unique case (op_i)
        jwh_pkg::OP_ADD: begin
          pos_d          = jwh_pkg::sat_inc(pos_q);
          push_o         = !excluded;
          cmd_o.kind     = jwh_pkg::CMD_ADD;
          cmd_o.in_range = sample_value_i < BINS_W;
          cmd_o.value    = sample_value_i;
        end
        jwh_pkg::OP_READ: begin
          push_o         = 1'b1;
          cmd_o.kind     = jwh_pkg::CMD_READ;
          cmd_o.in_range = bin_ext < BINS_W;
          cmd_o.value    = bin_ext;
        end
        jwh_pkg::OP_CLEAR: begin
          pos_d      = '0;
          push_o     = 1'b1;
          cmd_o.kind = jwh_pkg::CMD_CLEAR;
        end
        default: begin
          // Unused op code: the beat is taken and has no effect.
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= '0;
      skip_start_q  <= '0;
      skip_length_q <= '0;
    end else begin
      pos_q <= pos_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          jwh_pkg::REG_SKIP_START:  skip_start_q  <= cfg_data_i;
          jwh_pkg::REG_SKIP_LENGTH: skip_length_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/jwh_cmd_fifo.sv =====
// Short command queue between the front end and the histogram engine.
`timescale 1ns / 1ps
`default_nettype none
module jwh_cmd_fifo (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  jwh_pkg::cmd_t  push_data_i,
  input  wire            pop_i,
  output jwh_pkg::cmd_t  pop_data_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned CNT_W = jwh_pkg::CMD_PTR_W + 1;

  jwh_pkg::cmd_t                   entries_q [jwh_pkg::CMD_FIFO_DEPTH];
  logic [jwh_pkg::CMD_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]                count_q;
  logic                            do_push, do_pop;

  assign full_o     = count_q == CNT_W'(jwh_pkg::CMD_FIFO_DEPTH);
  assign empty_o    = count_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + jwh_pkg::CMD_PTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + jwh_pkg::CMD_PTR_W'(1);
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

// ===== src/jwh_back.sv =====
// Histogram engine: bin memory read-modify-write, totals, reads and clearing.
`timescale 1ns / 1ps
`default_nettype none
module jwh_back #(
  parameter int unsigned BINS = 4096
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                empty_i,
  input  jwh_pkg::cmd_t                      cmd_i,
  output logic                               pop_o,
  output logic                               init_done_o,
  output logic                               m_valid_o,
  input  wire                                m_ready_i,
  output logic [4*jwh_pkg::WORD_W-1:0]       m_data_o
);

  localparam int unsigned IDX_W = $clog2(BINS);
  localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(BINS - 1);
  localparam int unsigned W = jwh_pkg::WORD_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_READ,
    S_CLEAR
  } state_e;

  state_e            state_q;
  jwh_pkg::cmd_t     cmd_q;
  logic [IDX_W-1:0]  clr_addr_q;
  logic              init_done_q;
  logic [W-1:0]      max_q, ovf_q, kept_q;
  logic              out_valid_q;
  logic [4*W-1:0]    out_q;

  logic [W-1:0]      mem [BINS];
  logic [W-1:0]      rdata_q;
  logic              mem_re, mem_we;
  logic [IDX_W-1:0]  mem_raddr, mem_waddr;
  logic [W-1:0]      mem_wdata;
  logic              out_free;
  logic              out_load;

  assign pop_o       = (state_q == S_IDLE) && !empty_i;
  assign mem_re      = pop_o;
  assign mem_raddr   = cmd_i.value[IDX_W-1:0];
  assign mem_we      = (state_q == S_CLEAR) || ((state_q == S_ADD) && cmd_q.in_range);
  assign mem_waddr   = (state_q == S_CLEAR) ? clr_addr_q : cmd_q.value[IDX_W-1:0];
  assign mem_wdata   = (state_q == S_CLEAR) ? '0 : jwh_pkg::sat_inc(rdata_q);
  assign out_free    = !out_valid_q || m_ready_i;
  assign out_load    = (state_q == S_READ) && out_free;
  assign init_done_o = init_done_q;
  assign m_valid_o   = out_valid_q;
  assign m_data_o    = out_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cmd_q       <= '0;
      clr_addr_q  <= '0;
      init_done_q <= 1'b0;
      max_q       <= '0;
      ovf_q       <= '0;
      kept_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q       <= {kept_q, ovf_q, max_q, cmd_q.in_range ? rdata_q : {W{1'b0}}};
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            cmd_q <= cmd_i;
            unique case (cmd_i.kind)
              jwh_pkg::CMD_ADD: begin
                kept_q <= jwh_pkg::sat_inc(kept_q);
                if (cmd_i.value > max_q) max_q <= cmd_i.value;
                // Overflow samples never write the bin memory.
                if (cmd_i.in_range) begin
                  state_q <= S_ADD;
                end else begin
                  ovf_q <= jwh_pkg::sat_inc(ovf_q);
                end
              end
              jwh_pkg::CMD_READ: state_q <= S_READ;
              jwh_pkg::CMD_CLEAR: begin
                max_q      <= '0;
                ovf_q      <= '0;
                kept_q     <= '0;
                clr_addr_q <= '0;
                state_q    <= S_CLEAR;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_ADD: state_q <= S_IDLE;
        S_READ: begin
          // The registered bin word holds until the output register frees up.
          if (out_load) state_q <= S_IDLE;
        end
        S_CLEAR: begin
          if (clr_addr_q == LAST_BIN) begin
            init_done_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            clr_addr_q <= clr_addr_q + IDX_W'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/jwh_checker.sv =====
// Port-level checker for the jackknife histogram, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module jwh_checker #(
  parameter int unsigned BINS = 4096
) (
  input wire         clk_i,
  input wire         rst_ni,
  input wire         m_axis_tvalid,
  input wire         m_axis_tready,
  input wire [127:0] m_axis_tdata
);

  localparam logic [31:0] BINS_W = 32'(BINS);

  logic [31:0] freq, max_v, ovf, kept;

  assign freq  = m_axis_tdata[31:0];
  assign max_v = m_axis_tdata[63:32];
  assign ovf   = m_axis_tdata[95:64];
  assign kept  = m_axis_tdata[127:96];

  `JWH_ASSERT_STD(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")
  `JWH_ASSERT_STD(a_kept_ge_ovf, m_axis_tvalid |-> kept >= ovf, "overflow count exceeds kept total")
  `JWH_ASSERT_STD(a_kept_ge_freq, m_axis_tvalid |-> kept >= freq, "bin frequency exceeds kept total")
  `JWH_ASSERT_STD(a_ovf_max, m_axis_tvalid && (ovf != 32'd0) |-> max_v >= BINS_W, "overflow seen but maximum lies within the bins")

endmodule

bind jackknife_windowed_histogram_top jwh_checker #(.BINS(BINS)) u_jwh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== bench/tb_jackknife_windowed_histogram_top.sv =====
// Self-checking testbench for the jackknife windowed histogram top level.
`timescale 1ns / 1ps
module tb_jackknife_windowed_histogram_top;

  localparam int unsigned TB_BINS = 4096;
  localparam logic [1:0] OP_ADD = jwh_pkg::OP_ADD;
  localparam logic [1:0] OP_READ = jwh_pkg::OP_READ;
  localparam logic [1:0] OP_CLEAR = jwh_pkg::OP_CLEAR;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [0:0] REG_SKIP_START = jwh_pkg::REG_SKIP_START;
  localparam logic [0:0] REG_SKIP_LENGTH = jwh_pkg::REG_SKIP_LENGTH;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_COUNT = 8;

  typedef enum {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // Same layout as m_axis_tdata: bin_frequency sits in the lowest bits.
  typedef struct packed {
    logic [31:0] kept_total;
    logic [31:0] overflow_count;
    logic [31:0] max_value;
    logic [31:0] bin_frequency;
  } hist_result_t;

  typedef struct {
    logic [1:0]   op;
    logic [31:0]  value;
    logic [11:0]  idx;
    bit           typed;
    hist_result_t want;
  } dir_row_t;

  typedef struct {
    logic [31:0] skip_start;
    logic [31:0] skip_length;
    idle_mode_e  mode;
    int          items;
    bit          pressure;
  } phase_t;

  localparam hist_result_t EMPTY_RES = '0;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  wire          s_axis_tready;
  logic [47:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  wire          m_axis_tvalid;
  logic         m_axis_tready;
  wire  [127:0] m_axis_tdata;
  logic         cfg_we_i;
  logic [0:0]   cfg_idx_i;
  logic [31:0]  cfg_data_i;

  // Predictor state of the histogram and its registers.
  logic [31:0]  model_bins [TB_BINS];
  logic [31:0]  model_pos;
  logic [31:0]  model_max;
  logic [31:0]  model_ovf;
  logic [31:0]  model_kept;
  logic [31:0]  model_skip_start;
  logic [31:0]  model_skip_len;

  hist_result_t pending_reads[$];
  idle_mode_e   idle_mode = IDLE_NONE;
  bit           hold_request = 1'b0;
  int unsigned  cycle_count = 0;
  int           mismatches = 0;
  int           beats_in = 0;
  int           adds_kept = 0;
  int           adds_dropped = 0;
  int           clears = 0;
  int           results_seen = 0;

  dir_row_t     directed_rows [21];
  phase_t       phases [PHASE_COUNT];

  jackknife_windowed_histogram_top #(
    .BINS(TB_BINS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d reads pending.", cycle_count,
               pending_reads.size());
      $display("tb_jackknife_windowed_histogram_top: FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] bump_sat(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  task automatic wipe_model();
    foreach (model_bins[k]) model_bins[k] = '0;
    model_pos  = '0;
    model_max  = '0;
    model_ovf  = '0;
    model_kept = '0;
  endtask

  // Applies one accepted beat to the predictor; a read yields a result.
  task automatic predict_beat(input logic [1:0] op, input logic [31:0] value,
                              input logic [11:0] idx, output bit has_res,
                              output hist_result_t res);
    logic [31:0] pos;
    has_res = 1'b0;
    res = '0;
    case (op)
      OP_ADD: begin
        pos = model_pos;
        model_pos = bump_sat(model_pos);
        if (pos >= model_skip_start && (pos - model_skip_start) < model_skip_len) begin
          adds_dropped++;
        end else begin
          if (value < TB_BINS) model_bins[value[11:0]] = bump_sat(model_bins[value[11:0]]);
          else model_ovf = bump_sat(model_ovf);
          if (value > model_max) model_max = value;
          model_kept = bump_sat(model_kept);
          adds_kept++;
        end
      end
      OP_READ: begin
        has_res = 1'b1;
        res.bin_frequency  = (idx < TB_BINS) ? model_bins[idx] : '0;
        res.max_value      = model_max;
        res.overflow_count = model_ovf;
        res.kept_total     = model_kept;
      end
      OP_CLEAR: begin
        wipe_model();
        clears++;
      end
      default: begin
        // The unused op leaves everything as it was.
      end
    endcase
  endtask

  // Offers one beat, called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_beat(input logic [1:0] op, input logic [31:0] value,
                           input logic [11:0] idx, input bit typed,
                           input hist_result_t want);
    int unsigned gap_pct;
    bit has_res;
    hist_result_t pred;
    gap_pct = (idle_mode == IDLE_SENDER) ? 71 : (idle_mode == IDLE_BOTH) ? 37 : 0;
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {4'b0000, idx, value};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    beats_in++;
    predict_beat(op, value, idx, has_res, pred);
    if (has_res) pending_reads.push_back(typed ? want : pred);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_SKIP_START) model_skip_start = data;
    else model_skip_len = data;
  endtask

  // Every phase ends on a read, so its result marks the engine as done.
  task automatic drain(input int extra);
    s_axis_tvalid = 1'b0;
    while (pending_reads.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  // Receiver: random stalls by phase, plus one long hold-off on request.
  initial begin
    int hold_left;
    int unsigned stall_pct;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      stall_pct = (idle_mode == IDLE_RECEIVER) ? 71 : (idle_mode == IDLE_BOTH) ? 37 : 0;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    hist_result_t got;
    hist_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      results_seen++;
      if (pending_reads.size() == 0) begin
        $error("result beat %h arrived with no read pending", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_reads.pop_front();
        if (got.bin_frequency !== want.bin_frequency) begin
          $error("bin_frequency: expected %h, got %h", want.bin_frequency, got.bin_frequency);
          mismatches++;
        end
        if (got.max_value !== want.max_value) begin
          $error("max_value: expected %h, got %h", want.max_value, got.max_value);
          mismatches++;
        end
        if (got.overflow_count !== want.overflow_count) begin
          $error("overflow_count: expected %h, got %h", want.overflow_count,
                 got.overflow_count);
          mismatches++;
        end
        if (got.kept_total !== want.kept_total) begin
          $error("kept_total: expected %h, got %h", want.kept_total, got.kept_total);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int i;
    int p;
    int unsigned r;
    logic [1:0] op;
    logic [31:0] value;
    logic [11:0] idx;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    wipe_model();
    model_skip_start = '0;
    model_skip_len   = '0;

    // Expected values typed in as kept_total, overflow_count, max_value, bin_frequency.
    directed_rows = '{
      '{OP_READ,   32'd0,           12'h000, 1'b1, EMPTY_RES},
      '{OP_READ,   32'd0,           12'hFFF, 1'b1, EMPTY_RES},
      '{OP_ADD,    32'd0,           12'hFFF, 1'b0, EMPTY_RES},
      '{OP_ADD,    32'hFFFF_FFFF,   12'h000, 1'b0, EMPTY_RES},
      '{OP_ADD,    32'd4095,        12'h000, 1'b0, EMPTY_RES},
      '{OP_ADD,    32'd4096,        12'hFFF, 1'b0, EMPTY_RES},
      '{OP_UNUSED, 32'd5,           12'h005, 1'b0, EMPTY_RES},
      '{OP_READ,   32'hFFFF_FFFF,   12'h000, 1'b1, '{32'd4, 32'd2, 32'hFFFF_FFFF, 32'd1}},
      '{OP_READ,   32'd0,           12'hFFF, 1'b1, '{32'd4, 32'd2, 32'hFFFF_FFFF, 32'd1}},
      '{OP_READ,   32'd0,           12'h004, 1'b0, EMPTY_RES},
      '{OP_ADD,    32'd7,           12'h000, 1'b0, EMPTY_RES},
      '{OP_ADD,    32'd7,           12'h000, 1'b0, EMPTY_RES},
      '{OP_READ,   32'd0,           12'h007, 1'b0, EMPTY_RES},
      '{OP_CLEAR,  32'hFFFF_FFFF,   12'hFFF, 1'b0, EMPTY_RES},
      '{OP_READ,   32'd0,           12'h007, 1'b1, EMPTY_RES},
      '{OP_ADD,    32'd1,           12'h000, 1'b0, EMPTY_RES},
      '{OP_READ,   32'd0,           12'h001, 1'b1, '{32'd1, 32'd0, 32'd1, 32'd1}},
      '{OP_UNUSED, 32'hFFFF_FFFF,   12'hFFF, 1'b0, EMPTY_RES},
      '{OP_READ,   32'd0,           12'hFFF, 1'b0, EMPTY_RES},
      '{OP_ADD,    32'h8000_0000,   12'h000, 1'b0, EMPTY_RES},
      '{OP_READ,   32'd0,           12'h000, 1'b0, EMPTY_RES}
    };

    // A start past every reachable position excludes nothing, whatever the length.
    phases = '{
      '{32'd0,         32'd0,         IDLE_NONE,     100, 1'b0},
      '{32'd3,         32'd5,         IDLE_SENDER,   100, 1'b0},
      '{32'd0,         32'hFFFF_FFFF, IDLE_RECEIVER,  60, 1'b0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, IDLE_BOTH,     100, 1'b0},
      '{32'd20,        32'd40,        IDLE_NONE,     150, 1'b1},
      '{32'hFFFF_FFFF, 32'd0,         IDLE_SENDER,   100, 1'b0},
      '{32'd1,         32'd1,         IDLE_BOTH,     100, 1'b0},
      '{32'd0,         32'd64,        IDLE_RECEIVER,  90, 1'b0}
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[k]) begin
      push_beat(directed_rows[k].op, directed_rows[k].value, directed_rows[k].idx,
                directed_rows[k].typed, directed_rows[k].want);
    end
    drain(8);

    for (p = 0; p < PHASE_COUNT; p++) begin
      write_reg(REG_SKIP_START, phases[p].skip_start);
      write_reg(REG_SKIP_LENGTH, phases[p].skip_length);
      idle_mode = phases[p].mode;
      if (phases[p].pressure) hold_request = 1'b1;
      for (i = 0; i < phases[p].items; i++) begin
        r = $urandom_range(99);
        if (r < 70) op = OP_ADD;
        else if (r < 92) op = OP_READ;
        else if (r < 94) op = OP_CLEAR;
        else op = OP_UNUSED;
        // Mostly small values, so that bins fill up and reads find counts.
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: value = $urandom_range(15);
          6:       value = $urandom_range(TB_BINS - 1);
          7:       value = $urandom;
          8:       value = TB_BINS - 2 + $urandom_range(3);
          default: value = 32'hFFFF_FFFF - $urandom_range(3);
        endcase
        idx = $urandom_range(1) ? 12'($urandom_range(15)) : 12'($urandom);
        push_beat(op, value, idx, 1'b0, EMPTY_RES);
      end
      push_beat(OP_READ, $urandom, 12'($urandom_range(15)), 1'b0, EMPTY_RES);
      drain(8);
    end

    idle_mode = IDLE_NONE;
    drain(20);
    $display("Covered %0d input beats over %0d register settings: %0d samples kept,",
             beats_in, PHASE_COUNT + 1, adds_kept);
    $display("%0d dropped by the skip window, %0d clears, %0d result beats checked.",
             adds_dropped, clears, results_seen);
    if (mismatches == 0) begin
      $display("tb_jackknife_windowed_histogram_top: PASS");
    end else begin
      $display("tb_jackknife_windowed_histogram_top: FAIL");
    end
    $finish;
  end

endmodule
